[rtl/chtm_pkg.sv]
// Package for the chained hash table with mark.
// Holds operation and status codes, default sizes and the sequencer state type.
package chtm_pkg;
   localparam int unsigned BucketsDefault = 256;
   localparam int unsigned WaysDefault = 4;
   localparam int unsigned KeyWidth = 31;
   localparam int unsigned RecWidth = 32;
   localparam int unsigned TotalWidth = 11;
   localparam int unsigned CountWidth = 9;

   localparam logic [1:0] FuncInsert = 2'd0;
   localparam logic [1:0] FuncLookup = 2'd1;
   localparam logic [1:0] FuncMark = 2'd2;
   localparam logic [1:0] FuncDelete = 2'd3;

   localparam logic [1:0] StatusOk = 2'd0;
   localparam logic [1:0] StatusNotFound = 2'd1;
   localparam logic [1:0] StatusMarked = 2'd2;
   localparam logic [1:0] StatusFull = 2'd3;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b0_0000_0001,
      ST_DIV   = 9'b0_0000_0010,
      ST_FILL  = 9'b0_0000_0100,
      ST_RD    = 9'b0_0000_1000,
      ST_CMP   = 9'b0_0001_0000,
      ST_SHIFT = 9'b0_0010_0000,
      ST_DONE  = 9'b0_0100_0000,
      ST_OUT   = 9'b0_1000_0000,
      ST_CLR   = 9'b1_0000_0000
   } state_type;
endpackage

[rtl/chtm_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module chtm_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

[rtl/chained_hash_table_with_mark.sv]
// Top level of the chained hash table with mark: sequencer, serial modulo, slot memory.
// Uses chtm_pkg and chtm_ram.
//
// Each item first takes the restoring modulo of the key by the
// bucket count (one quotient bit per cycle); all but an insert then scan the
// bucket from its newest slot down through the registered-read slot memory, with
// a read state and a compare state per slot visited, and a delete then moves each
// later slot down by one. Slots are never read beyond a bucket's fill; the
// per-bucket fill counts sit in a small RAM that a clearing pass over all
// BUCKETS entries (256 by default) zeroes after reset, before the first item is
// taken. One item is in work at a time.
module chained_hash_table_with_mark #(
   parameter int unsigned BUCKETS = chtm_pkg::BucketsDefault,
   parameter int unsigned WAYS = chtm_pkg::WaysDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [8:0]  csr_bucket_count,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [30:0] req_key,
   input  logic [31:0] req_record,
   input  logic        req_marked_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_record_out,
   output logic        rsp_marked_out,
   output logic [10:0] rsp_entry_total,
   output logic [10:0] rsp_marked_total
);
   localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int unsigned WW = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int unsigned FW = $clog2(WAYS + 1);
   localparam int unsigned SLOTS = BUCKETS * WAYS;
   localparam int unsigned AW = $clog2(SLOTS) > 0 ? $clog2(SLOTS) : 1;
   localparam int unsigned DW = 17;
   localparam int unsigned MW = chtm_pkg::KeyWidth + chtm_pkg::RecWidth + 1;
   localparam int unsigned KW = chtm_pkg::KeyWidth;

   chtm_pkg::state_type state_ff, state_in;
   logic [8:0]  cfg_ff, cfg_in;
   logic [1:0]  func_ff, func_in;
   logic [KW-1:0] key_ff, key_in;
   logic [31:0] rec_ff, rec_in;
   logic        mk_ff, mk_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [4:0]  bit_ff, bit_in;
   logic [DW-1:0] div_ff, div_in;
   logic [BW-1:0] bkt_ff, bkt_in;
   logic [BW-1:0] clr_ff, clr_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [FW-1:0] idx_ff, idx_in;
   logic [10:0] ent_ff, ent_in, mrk_ff, mrk_in;
   logic [1:0]  st_ff, st_in;
   logic [31:0] ro_ff, ro_in;
   logic        mo_ff, mo_in;
   logic        fill_we;
   logic [FW-1:0] fill_wd;
   logic [BW-1:0] fill_wa, fill_ra;
   logic [FW-1:0] fill_rd;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [MW-1:0] wr_data, rd_data;
   logic [DW-1:0] trial;
   logic [AW-1:0] base;

   chtm_ram #(.WIDTH(MW), .DEPTH(SLOTS)) u_slots (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   chtm_ram #(.WIDTH(FW), .DEPTH(BUCKETS)) u_fills (
      .clock(clock), .wr_en(fill_we), .wr_addr(fill_wa), .wr_data(fill_wd),
      .rd_addr(fill_ra), .rd_data(fill_rd)
   );

   assign csr_ready = (state_ff == chtm_pkg::ST_IDLE);
   assign req_ready = (state_ff == chtm_pkg::ST_IDLE) && !csr_valid;
   assign rsp_valid = (state_ff == chtm_pkg::ST_OUT);
   assign rsp_status = st_ff;
   assign rsp_record_out = ro_ff;
   assign rsp_marked_out = mo_ff;
   assign rsp_entry_total = ent_ff;
   assign rsp_marked_total = mrk_ff;

   assign base = AW'(bkt_ff) * AW'(WAYS);
   assign trial = {rem_ff[DW-2:0], key_ff[bit_ff]};
   assign fill_ra = BW'(rem_in);

   always_comb begin
      state_in = state_ff;
      cfg_in = cfg_ff;
      func_in = func_ff;
      key_in = key_ff;
      rec_in = rec_ff;
      mk_in = mk_ff;
      rem_in = rem_ff;
      bit_in = bit_ff;
      div_in = div_ff;
      bkt_in = bkt_ff;
      clr_in = clr_ff;
      fill_in = fill_ff;
      idx_in = idx_ff;
      ent_in = ent_ff;
      mrk_in = mrk_ff;
      st_in = st_ff;
      ro_in = ro_ff;
      mo_in = mo_ff;
      fill_we = 1'b0;
      fill_wd = fill_ff;
      fill_wa = bkt_ff;
      wr_en = 1'b0;
      wr_addr = base + AW'(idx_ff);
      wr_data = {key_ff, rec_ff, mk_ff};
      rd_addr = base + AW'(idx_ff);
      unique case (state_ff)
         chtm_pkg::ST_CLR: begin
            fill_we = 1'b1;
            fill_wd = '0;
            fill_wa = clr_ff;
            clr_in = clr_ff + BW'(1);
            if (32'(clr_ff) == BUCKETS - 1) begin
               state_in = chtm_pkg::ST_IDLE;
            end
         end
         chtm_pkg::ST_IDLE: begin
            if (csr_valid) begin
               cfg_in = csr_bucket_count;
            end else if (req_valid) begin
               func_in = req_func;
               key_in = req_key;
               rec_in = req_record;
               mk_in = req_marked_in;
               rem_in = '0;
               bit_in = 5'(KW - 1);
               if (cfg_ff == 9'd0) begin
                  div_in = DW'(1);
               end else if (32'(cfg_ff) > BUCKETS) begin
                  div_in = DW'(BUCKETS);
               end else begin
                  div_in = DW'(cfg_ff);
               end
               state_in = chtm_pkg::ST_DIV;
            end
         end
         chtm_pkg::ST_DIV: begin
            rem_in = (trial >= div_ff) ? trial - div_ff : trial;
            bit_in = bit_ff - 5'd1;
            if (bit_ff == 5'd0) begin
               state_in = chtm_pkg::ST_FILL;
            end
         end
         chtm_pkg::ST_FILL: begin
            bkt_in = BW'(rem_ff);
            fill_in = fill_rd;
            idx_in = fill_rd;
            ro_in = '0;
            mo_in = 1'b0;
            if (func_ff == chtm_pkg::FuncInsert) begin
               state_in = chtm_pkg::ST_DONE;
            end else if (fill_rd == '0) begin
               st_in = chtm_pkg::StatusNotFound;
               state_in = chtm_pkg::ST_OUT;
            end else begin
               idx_in = fill_rd - FW'(1);
               state_in = chtm_pkg::ST_RD;
            end
         end
         chtm_pkg::ST_RD: begin
            state_in = chtm_pkg::ST_CMP;
         end
         chtm_pkg::ST_CMP: begin
            if (rd_data[MW-1 -: KW] == key_ff) begin
               ro_in = rd_data[32:1];
               mo_in = rd_data[0];
               st_in = chtm_pkg::StatusOk;
               if (func_ff == chtm_pkg::FuncMark) begin
                  if (rd_data[0]) begin
                     st_in = chtm_pkg::StatusMarked;
                  end else begin
                     wr_en = 1'b1;
                     wr_data = {rd_data[MW-1:1], 1'b1};
                     mo_in = 1'b1;
                     mrk_in = mrk_ff + 11'd1;
                  end
                  state_in = chtm_pkg::ST_OUT;
               end else if (func_ff == chtm_pkg::FuncDelete) begin
                  ent_in = ent_ff - 11'd1;
                  if (rd_data[0]) begin
                     mrk_in = mrk_ff - 11'd1;
                  end
                  fill_we = 1'b1;
                  fill_wd = fill_ff - FW'(1);
                  fill_in = fill_ff - FW'(1);
                  state_in = chtm_pkg::ST_SHIFT;
               end else begin
                  state_in = chtm_pkg::ST_OUT;
               end
            end else if (idx_ff == '0) begin
               st_in = chtm_pkg::StatusNotFound;
               state_in = chtm_pkg::ST_OUT;
            end else begin
               idx_in = idx_ff - FW'(1);
               rd_addr = base + AW'(idx_ff - FW'(1));
               state_in = chtm_pkg::ST_RD;
            end
         end
         chtm_pkg::ST_SHIFT: begin
            // idx is the hole; fill_ff is now the new fill
            if (idx_ff >= fill_ff) begin
               state_in = chtm_pkg::ST_OUT;
            end else begin
               rd_addr = base + AW'(idx_ff + FW'(1));
               state_in = chtm_pkg::ST_DONE;
            end
         end
         chtm_pkg::ST_DONE: begin
            if (func_ff == chtm_pkg::FuncInsert) begin
               if (32'(fill_ff) >= WAYS) begin
                  st_in = chtm_pkg::StatusFull;
               end else begin
                  wr_en = 1'b1;
                  fill_we = 1'b1;
                  fill_wd = fill_ff + FW'(1);
                  ent_in = ent_ff + 11'd1;
                  mrk_in = mrk_ff + 11'(mk_ff);
                  ro_in = rec_ff;
                  mo_in = mk_ff;
                  st_in = chtm_pkg::StatusOk;
               end
               state_in = chtm_pkg::ST_OUT;
            end else begin
               wr_en = 1'b1;
               wr_data = rd_data;
               idx_in = idx_ff + FW'(1);
               state_in = chtm_pkg::ST_SHIFT;
            end
         end
         chtm_pkg::ST_OUT: begin
            if (rsp_ready) begin
               state_in = chtm_pkg::ST_IDLE;
            end
         end
         default: state_in = chtm_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= chtm_pkg::ST_CLR;
         cfg_ff <= 9'd256;
         ent_ff <= '0;
         mrk_ff <= '0;
         clr_ff <= '0;
      end else begin
         state_ff <= state_in;
         cfg_ff <= cfg_in;
         ent_ff <= ent_in;
         mrk_ff <= mrk_in;
         clr_ff <= clr_in;
      end
      func_ff <= func_in;
      key_ff <= key_in;
      rec_ff <= rec_in;
      mk_ff <= mk_in;
      rem_ff <= rem_in;
      bit_ff <= bit_in;
      div_ff <= div_in;
      bkt_ff <= bkt_in;
      fill_ff <= fill_in;
      idx_ff <= idx_in;
      st_ff <= st_in;
      ro_ff <= ro_in;
      mo_ff <= mo_in;
   end

   a_busy_no_req: assert property (@(posedge clock) disable iff (reset)
      (state_ff != chtm_pkg::ST_IDLE) |-> !req_ready)
      else $error("ready while busy");
   a_mark_le_ent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (mrk_ff <= ent_ff))
      else $error("marked count above entry count");
   a_full_no_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == chtm_pkg::StatusFull) |-> (ro_ff == '0))
      else $error("full bucket reported payload");
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == chtm_pkg::ST_FILL) |-> (rem_ff < div_ff))
      else $error("remainder out of range");
endmodule

[tb/sv/tb_chained_hash_table_with_mark.sv]
// Testbench for chained_hash_table_with_mark: drives insert, lookup, mark and delete items
// and checks each response against a behavioral table model. Depends on chtm_pkg and the RTL.
`timescale 1ns / 1ps

module tb_chained_hash_table_with_mark;

   localparam int Buckets = 256;
   localparam int Ways = 4;
   localparam int WatchLimit = 20000;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] record_out;
      logic        marked_out;
      logic [10:0] entry_total;
      logic [10:0] marked_total;
   } rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [8:0]  csr_bucket_count = 9'd0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_func = chtm_pkg::FuncInsert;
   logic [30:0] req_key = 31'd0;
   logic [31:0] req_record = 32'd0;
   logic        req_marked_in = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_record_out;
   logic        rsp_marked_out;
   logic [10:0] rsp_entry_total;
   logic [10:0] rsp_marked_total;

   chained_hash_table_with_mark dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_bucket_count(csr_bucket_count),
      .req_valid(req_valid), .req_ready(req_ready), .req_func(req_func),
      .req_key(req_key), .req_record(req_record), .req_marked_in(req_marked_in),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_record_out(rsp_record_out), .rsp_marked_out(rsp_marked_out),
      .rsp_entry_total(rsp_entry_total), .rsp_marked_total(rsp_marked_total)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   logic [30:0] tbl_key [Buckets*Ways];
   logic [31:0] tbl_rec [Buckets*Ways];
   logic        tbl_mark [Buckets*Ways];
   int          tbl_fill [Buckets];
   logic [10:0] num_entries;
   logic [10:0] num_marked;
   logic [8:0]  divisor_reg;

   rsp_type pending_rsp [$];
   int   errors = 0;
   int   items_sent = 0;
   int   rsps_seen = 0;
   int   idle_pct = 0;
   int   stall_pct = 0;
   int   quiet_cycles = 0;
   int   status_hits [4];

   function automatic rsp_type table_apply(logic [1:0] func, logic [30:0] key,
                                           logic [31:0] rec, logic mk_in);
      int n, b, base, slot, last;
      rsp_type r;
      n = divisor_reg;
      if (n == 0) n = 1;
      if (n > Buckets) n = Buckets;
      b = key % n;
      base = b * Ways;
      r = '0;
      r.status = chtm_pkg::StatusOk;
      if (func == chtm_pkg::FuncInsert) begin
         if (tbl_fill[b] >= Ways) begin
            r.status = chtm_pkg::StatusFull;
         end else begin
            tbl_key[base + tbl_fill[b]] = key;
            tbl_rec[base + tbl_fill[b]] = rec;
            tbl_mark[base + tbl_fill[b]] = mk_in;
            tbl_fill[b]++;
            num_entries++;
            num_marked += 11'(mk_in);
            r.record_out = rec;
            r.marked_out = mk_in;
         end
      end else begin
         slot = -1;
         for (int i = tbl_fill[b] - 1; i >= 0; i--)
            if (slot < 0 && tbl_key[base + i] == key) slot = base + i;
         if (slot < 0) begin
            r.status = chtm_pkg::StatusNotFound;
         end else begin
            r.record_out = tbl_rec[slot];
            r.marked_out = tbl_mark[slot];
            if (func == chtm_pkg::FuncMark) begin
               if (tbl_mark[slot]) begin
                  r.status = chtm_pkg::StatusMarked;
               end else begin
                  tbl_mark[slot] = 1'b1;
                  r.marked_out = 1'b1;
                  num_marked++;
               end
            end else if (func == chtm_pkg::FuncDelete) begin
               last = base + tbl_fill[b] - 1;
               for (int u = slot; u < last; u++) begin
                  tbl_key[u] = tbl_key[u+1];
                  tbl_rec[u] = tbl_rec[u+1];
                  tbl_mark[u] = tbl_mark[u+1];
               end
               tbl_fill[b]--;
               if (num_entries > 0) num_entries--;
               if (r.marked_out && num_marked > 0) num_marked--;
            end
         end
      end
      r.entry_total = num_entries;
      r.marked_total = num_marked;
      return r;
   endfunction

   task automatic send_item(logic [1:0] func, logic [30:0] key, logic [31:0] rec, logic mk);
      @(posedge clock);
      while ($urandom_range(99) < idle_pct) @(posedge clock);
      req_valid <= 1'b1;
      req_func <= func;
      req_key <= key;
      req_record <= rec;
      req_marked_in <= mk;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_rsp.push_back(table_apply(func, key, rec, mk));
      items_sent++;
      req_valid <= 1'b0;
   endtask

   task automatic drain();
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_divisor(logic [8:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_bucket_count <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      divisor_reg = value;
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               $error("response with nothing expected");
               errors++;
            end else begin
               rsp_type e;
               e = pending_rsp.pop_front();
               rsps_seen++;
               status_hits[rsp_status]++;
               if (rsp_status !== e.status) begin
                  $error("status exp %0d got %0d", e.status, rsp_status); errors++;
               end
               if (rsp_record_out !== e.record_out) begin
                  $error("record_out exp %h got %h", e.record_out, rsp_record_out); errors++;
               end
               if (rsp_marked_out !== e.marked_out) begin
                  $error("marked_out exp %0d got %0d", e.marked_out, rsp_marked_out); errors++;
               end
               if (rsp_entry_total !== e.entry_total) begin
                  $error("entry_total exp %0d got %0d", e.entry_total, rsp_entry_total); errors++;
               end
               if (rsp_marked_total !== e.marked_total) begin
                  $error("marked_total exp %0d got %0d", e.marked_total, rsp_marked_total);
                  errors++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic test_directed();
      send_item(chtm_pkg::FuncLookup, 31'd5, 32'd0, 1'b0);
      send_item(chtm_pkg::FuncMark, 31'd5, 32'd0, 1'b0);
      send_item(chtm_pkg::FuncDelete, 31'd5, 32'd0, 1'b0);
      send_item(chtm_pkg::FuncInsert, 31'h7FFFFFFF, 32'hFFFFFFFF, 1'b1);
      send_item(chtm_pkg::FuncInsert, 31'd0, 32'd0, 1'b0);
      send_item(chtm_pkg::FuncMark, 31'h7FFFFFFF, 32'd0, 1'b0);
      send_item(chtm_pkg::FuncMark, 31'd0, 32'd0, 1'b0);
      send_item(chtm_pkg::FuncMark, 31'd0, 32'd0, 1'b0);
      for (int i = 0; i < 5; i++)
         send_item(chtm_pkg::FuncInsert, 31'd7 + 31'(256 * i), 32'hA5A50000 + 32'(i), i[0]);
      send_item(chtm_pkg::FuncInsert, 31'd7, 32'h11111111, 1'b0);
      send_item(chtm_pkg::FuncLookup, 31'd7, 32'd0, 1'b0);
      send_item(chtm_pkg::FuncDelete, 31'd263, 32'd0, 1'b0);
      send_item(chtm_pkg::FuncLookup, 31'd1031, 32'd0, 1'b0);
      send_item(chtm_pkg::FuncDelete, 31'h7FFFFFFF, 32'd0, 1'b0);
      send_item(chtm_pkg::FuncLookup, 31'h7FFFFFFF, 32'd0, 1'b0);
      send_item(chtm_pkg::FuncDelete, 31'd0, 32'd0, 1'b0);
   endtask

   task automatic test_divisor_extremes();
      write_divisor(9'd0);
      send_item(chtm_pkg::FuncInsert, 31'd12345, 32'h1, 1'b0);
      send_item(chtm_pkg::FuncInsert, 31'd99, 32'h2, 1'b1);
      send_item(chtm_pkg::FuncLookup, 31'd12345, 32'd0, 1'b0);
      write_divisor(9'd511);
      send_item(chtm_pkg::FuncInsert, 31'd300, 32'h3, 1'b0);
      send_item(chtm_pkg::FuncLookup, 31'd99, 32'd0, 1'b0);
      write_divisor(9'd1);
      send_item(chtm_pkg::FuncDelete, 31'd99, 32'd0, 1'b0);
      send_item(chtm_pkg::FuncLookup, 31'd300, 32'd0, 1'b0);
   endtask

   task automatic test_random(int count, int key_span);
      logic [1:0] f;
      logic [30:0] k;
      for (int i = 0; i < count; i++) begin
         f = 2'($urandom_range(3));
         if ($urandom_range(9) == 0) k = 31'($urandom);
         else k = 31'($urandom_range(key_span));
         send_item(f, k, $urandom, 1'($urandom_range(1)));
      end
   endtask

   task automatic test_phases();
      int divs [6] = '{256, 3, 1, 17, 200, 64};
      for (int p = 0; p < 6; p++) begin
         write_divisor(9'(divs[p]));
         case (p % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 46; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 46; end
            default: begin idle_pct = 18; stall_pct = 18; end
         endcase
         test_random(150, 40);
         drain();
         test_random(150, 2000);
      end
      idle_pct = 0;
      stall_pct = 0;
   endtask

   initial begin
      foreach (tbl_fill[i]) tbl_fill[i] = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
      num_entries = 0;
      num_marked = 0;
      divisor_reg = 9'd256;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_divisor_extremes();
      test_phases();
      drain();
      $display("covered %0d items, %0d responses; ok %0d, missing %0d, marked %0d, full %0d",
               items_sent, rsps_seen, status_hits[0], status_hits[1], status_hits[2],
               status_hits[3]);
      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule
